// File: hdl/assert_macros.svh
// Assertion helpers used by box_non_max_suppression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/bnms_pkg.sv
package bnms_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned MAX_BOXES  = 64;
  localparam int unsigned CFG_W      = 8;

  // Configuration register indexes.
  localparam logic REG_OVERLAP_NUM = 1'b0;
  localparam logic REG_OVERLAP_DEN = 1'b1;

  localparam logic [CFG_W-1:0] OVERLAP_NUM_RST = 8'd1;
  localparam logic [CFG_W-1:0] OVERLAP_DEN_RST = 8'd5;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic                  last_box;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] kept_x;
    logic [COORD_BITS-1:0] kept_y;
    logic [COORD_BITS-1:0] kept_width;
    logic [COORD_BITS-1:0] kept_height;
    logic                  last_kept;
    logic                  overflowed;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan_pick;
    logic scan_supp;
    logic kill_best;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic alive_none;
  } status_t;

endpackage

// File: hdl/bnms_ctrl.sv
module bnms_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  bnms_pkg::status_t  status_i,
  output bnms_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_PICK = 4'b0010,
    ST_SUPP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_pick = 1'b1;
            state_d         = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (status_i.scan_done) begin
          cmd_o.kill_best = 1'b1;
          cmd_o.scan_supp = 1'b1;
          state_d         = ST_SUPP;
        end
      end
      ST_SUPP: begin
        if (status_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.alive_none) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.scan_pick = 1'b1;
            state_d         = ST_PICK;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/bnms_datapath.sv
module bnms_datapath #(
  parameter int unsigned MAX_BOXES = bnms_pkg::MAX_BOXES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bnms_pkg::CFG_W-1:0]    cfg_data_i,
  input  bnms_pkg::in_item_t            in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output bnms_pkg::out_item_t           out_data_o,
  input  bnms_pkg::cmd_t                cmd_i,
  output bnms_pkg::status_t             status_o
);

  localparam int unsigned CW   = bnms_pkg::COORD_BITS;
  localparam int unsigned KW   = bnms_pkg::CFG_W;
  localparam int unsigned IdxW = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  // Configuration.
  logic [KW-1:0] num_q, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= bnms_pkg::OVERLAP_NUM_RST;
      den_q <= bnms_pkg::OVERLAP_DEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bnms_pkg::REG_OVERLAP_NUM) begin
        num_q <= cfg_data_i;
      end else begin
        den_q <= cfg_data_i;
      end
    end
  end

  // Box memory.
  bnms_pkg::box_t mem_q [MAX_BOXES];
  bnms_pkg::box_t rd_box_q;
  bnms_pkg::box_t wr_box;

  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic [MAX_BOXES-1:0] alive_q;
  logic                 store_ok;

  assign store_ok = (count_q < CntW'(MAX_BOXES));
  assign wr_box   = '{x: in_data_i.box_x, y: in_data_i.box_y,
                      w: in_data_i.box_width, h: in_data_i.box_height};

  // Scan address generator.
  logic            scan_q, supp_mode_q;
  logic [CntW-1:0] addr_q;
  logic            issue;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  assign issue = scan_q && (addr_q < count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      mem_q[count_q[IdxW-1:0]] <= wr_box;
    end
    if (issue) begin
      rd_box_q <= mem_q[addr_q[IdxW-1:0]];
    end
    rd_idx_q <= addr_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= 1'b0;
      supp_mode_q <= 1'b0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.scan_pick || cmd_i.scan_supp) begin
        scan_q      <= 1'b1;
        supp_mode_q <= cmd_i.scan_supp;
        addr_q      <= '0;
      end else if (issue) begin
        addr_q <= addr_q + CntW'(1);
      end else begin
        scan_q <= 1'b0;
      end
    end
  end

  // Pick: largest bottom edge, later entry wins a tie.
  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  bnms_pkg::box_t  best_box_q;
  logic [CW:0]     best_bot_q;
  logic [CW:0]     rd_bot;
  logic            pick_take;

  assign rd_bot    = {1'b0, rd_box_q.y} + {1'b0, rd_box_q.h};
  assign pick_take = rd_vld_q && !supp_mode_q && alive_q[rd_idx_q] &&
                     (!found_q || (rd_bot >= best_bot_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_pick) begin
      found_q <= 1'b0;
    end else if (pick_take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick_take) begin
      best_idx_q <= rd_idx_q;
      best_box_q <= rd_box_q;
      best_bot_q <= rd_bot;
    end
  end

  // Suppression pipeline: overlap extents, then products, then the compare.
  logic [CW:0]     px2, qx2, py2, qy2, xx2, yy2;
  logic [CW-1:0]   xx1, yy1;
  logic [CW+1:0]   xe, ye, xs, ys, w_full, h_full;
  logic [CW:0]     ov_w, ov_h;

  assign px2  = {1'b0, best_box_q.x} + {1'b0, best_box_q.w};
  assign qx2  = {1'b0, rd_box_q.x} + {1'b0, rd_box_q.w};
  assign py2  = {1'b0, best_box_q.y} + {1'b0, best_box_q.h};
  assign qy2  = {1'b0, rd_box_q.y} + {1'b0, rd_box_q.h};
  assign xx2  = (px2 < qx2) ? px2 : qx2;
  assign yy2  = (py2 < qy2) ? py2 : qy2;
  assign xx1  = (best_box_q.x > rd_box_q.x) ? best_box_q.x : rd_box_q.x;
  assign yy1  = (best_box_q.y > rd_box_q.y) ? best_box_q.y : rd_box_q.y;
  assign xe   = {1'b0, xx2} + (CW+2)'(1);
  assign ye   = {1'b0, yy2} + (CW+2)'(1);
  assign xs   = {2'b00, xx1};
  assign ys   = {2'b00, yy1};
  assign w_full = xe - xs;
  assign h_full = ye - ys;
  assign ov_w = (xe > xs) ? w_full[CW:0] : '0;
  assign ov_h = (ye > ys) ? h_full[CW:0] : '0;

  logic              s1_vld_q, s2_vld_q;
  logic [IdxW-1:0]   s1_idx_q, s2_idx_q;
  logic [CW:0]       s1_w_q, s1_h_q;
  logic [2*CW-1:0]   s1_area_q;
  logic [2*CW+1:0]   s2_wh_q;
  logic [2*CW+KW-1:0] s2_rhs_q;
  logic [2*CW+KW+1:0] lhs;
  logic              hit;

  assign lhs = s2_wh_q * den_q;
  assign hit = s2_vld_q && (lhs > {2'b00, s2_rhs_q});

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= rd_idx_q;
    s1_w_q    <= ov_w;
    s1_h_q    <= ov_h;
    s1_area_q <= rd_box_q.w * rd_box_q.h;
    s2_idx_q  <= s1_idx_q;
    s2_wh_q   <= s1_w_q * s1_h_q;
    s2_rhs_q  <= num_q * s1_area_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= rd_vld_q && supp_mode_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  // Set bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      alive_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      alive_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (store_ok) begin
          alive_q[count_q[IdxW-1:0]] <= 1'b1;
          count_q <= count_q + CntW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.kill_best) begin
        alive_q[best_idx_q] <= 1'b0;
      end
      if (hit) begin
        alive_q[s2_idx_q] <= 1'b0;
      end
    end
  end

  // Output register.
  logic                out_vld_q;
  bnms_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= '{kept_x: best_box_q.x, kept_y: best_box_q.y,
                 kept_width: best_box_q.w, kept_height: best_box_q.h,
                 last_kept: ~|alive_q, overflowed: ovf_q};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign status_o.scan_done  = !scan_q && !rd_vld_q && !s1_vld_q && !s2_vld_q;
  assign status_o.out_free   = !out_vld_q || out_ready_i;
  assign status_o.alive_none = ~|alive_q;

endmodule

// File: hdl/box_non_max_suppression.sv
// Loading takes one box per cycle while in_ready_o is high; the item with last_box set
// starts suppression. Each kept box takes a pick scan over the stored boxes, then a
// suppression scan over them, then a hand-off of the item to the output register once
// that register is free. The next set loads only after the final result of the set
// has been handed over. Reset (rst_ni low, asynchronous) empties the set, drops any
// pending result and restores overlap_num to 1 and overlap_den to 5.
`include "assert_macros.svh"

module box_non_max_suppression #(
  parameter int unsigned MAX_BOXES = bnms_pkg::MAX_BOXES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bnms_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bnms_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bnms_pkg::out_item_t        out_data_o
);

  bnms_pkg::cmd_t    cmd;
  bnms_pkg::status_t status;

  bnms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_box),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bnms_datapath #(
    .MAX_BOXES (MAX_BOXES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // A new result never overwrites one still waiting.
  `ASSERT_IMPLY(a_emit_free, clk_i, rst_ni, cmd.emit, status.out_free)
  // The last box of a set stops loading until suppression ends.
  `ASSERT_NEXT(a_last_stops, clk_i, rst_ni,
               in_valid_i && in_ready_o && in_data_i.last_box, !in_ready_o)
  // A set is cleared only together with its final result.
  `ASSERT_IMPLY(a_clear_last, clk_i, rst_ni, cmd.clear, cmd.emit && status.alive_none)

endmodule

// File: test/tb.sv
module tb;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic                       cfg_idx_i = bnms_pkg::REG_OVERLAP_NUM;
  logic [bnms_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  bnms_pkg::in_item_t         in_data_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  bnms_pkg::out_item_t        out_data_o;

  box_non_max_suppression DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model copy of the block state.
  bnms_pkg::box_t      set_boxes[$];
  logic                set_dropped;
  logic [7:0]          thr_num, thr_den;
  bnms_pkg::out_item_t kept_q[$];

  int errors = 0;
  int idle_in_pct = 0, idle_out_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // A directed row; typed rows carry their expected result.
  typedef struct {
    bnms_pkg::in_item_t  stim;
    bit                  typed;
    bnms_pkg::out_item_t want;
  } row_t;

  task automatic report(input string what);
    $display("tb: mismatch: %s", what);
    errors++;
  endtask

  function automatic logic overlaps_too_much(input bnms_pkg::box_t p,
                                             input bnms_pkg::box_t q);
    longint xx1, yy1, xx2, yy2, w, h;
    longint unsigned lhs, rhs;
    xx1 = (p.x > q.x) ? longint'(p.x) : longint'(q.x);
    yy1 = (p.y > q.y) ? longint'(p.y) : longint'(q.y);
    xx2 = ((longint'(p.x) + p.w) < (longint'(q.x) + q.w)) ?
          (longint'(p.x) + p.w) : (longint'(q.x) + q.w);
    yy2 = ((longint'(p.y) + p.h) < (longint'(q.y) + q.h)) ?
          (longint'(p.y) + p.h) : (longint'(q.y) + q.h);
    w = xx2 - xx1 + 1; if (w < 0) w = 0;
    h = yy2 - yy1 + 1; if (h < 0) h = 0;
    lhs = longint'(w) * h * thr_den;
    rhs = longint'(thr_num) * (longint'(q.w) * q.h);
    return lhs > rhs;
  endfunction

  task automatic predict_box(input bnms_pkg::in_item_t it);
    bnms_pkg::box_t b;
    bit alive [bnms_pkg::MAX_BOXES];
    int best, n;
    longint unsigned bot, best_bot;
    bnms_pkg::out_item_t o;
    b = '{it.box_x, it.box_y, it.box_width, it.box_height};
    if (set_boxes.size() < bnms_pkg::MAX_BOXES) set_boxes = {set_boxes, b};
    else set_dropped = 1'b1;
    if (!it.last_box) return;
    foreach (set_boxes[i]) alive[i] = 1'b1;
    n = 0;
    forever begin
      best = -1; best_bot = 0;
      foreach (set_boxes[i]) begin
        bot = longint'(set_boxes[i].y) + set_boxes[i].h;
        if (alive[i] && (best < 0 || bot >= best_bot)) begin
          best = i; best_bot = bot;
        end
      end
      if (best < 0) break;
      alive[best] = 1'b0;
      foreach (set_boxes[k])
        if (alive[k] && overlaps_too_much(set_boxes[best], set_boxes[k])) alive[k] = 1'b0;
      o = '{set_boxes[best].x, set_boxes[best].y, set_boxes[best].w, set_boxes[best].h,
            1'b0, set_dropped};
      kept_q = {kept_q, o};
      n++;
    end
    if (n > 0) kept_q[kept_q.size()-1].last_kept = 1'b1;
    set_boxes.delete();
    set_dropped = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (kept_q.size() == 0) report("result with nothing expected");
      else begin
        bnms_pkg::out_item_t e;
        e = kept_q.pop_front();
        if (out_data_o.kept_x != e.kept_x) report("kept_x");
        if (out_data_o.kept_y != e.kept_y) report("kept_y");
        if (out_data_o.kept_width != e.kept_width) report("kept_width");
        if (out_data_o.kept_height != e.kept_height) report("kept_height");
        if (out_data_o.last_kept != e.last_kept) report("last_kept");
        if (out_data_o.overflowed != e.overflowed) report("overflowed");
      end
    end
  end

  // Watchdog: the longest quiet stretch is the hold-off on the result side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 60000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Valid stays high after an item is taken so that the next one can follow at once;
  // it drops on an idle cycle or in drain.
  task automatic offer(input bnms_pkg::in_item_t it);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_box(input bnms_pkg::in_item_t it);
    offer(it);
    predict_box(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bnms_pkg::REG_OVERLAP_NUM) thr_num = val; else thr_den = val;
    @(posedge clk_i);
  endtask

  function automatic bnms_pkg::in_item_t rand_box(input logic last, input int span);
    bnms_pkg::in_item_t it;
    it.box_x = 12'($urandom_range(span));
    it.box_y = 12'($urandom_range(span));
    it.box_width = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(span / 2));
    it.box_height = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(span / 2));
    it.last_box = last;
    return it;
  endfunction

  task automatic send_set(input int n, input int span);
    for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1, span));
  endtask

  // Directed rows: {{x, y, w, h, last}, typed, {x, y, w, h, last_kept, overflowed}}.
  row_t rows [11] = '{
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0}},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1}, 1'b1,
      '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0}},
    '{'{12'd10, 12'd10, 12'd20, 12'd20, 1'b0}, 1'b0, '0},
    '{'{12'd12, 12'd12, 12'd20, 12'd20, 1'b0}, 1'b0, '0},
    '{'{12'd500, 12'd500, 12'd10, 12'd10, 1'b1}, 1'b0, '0},
    '{'{12'd0, 12'd50, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd40, 12'd10, 12'd20, 1'b1}, 1'b0, '0},
    '{'{12'd5, 12'd5, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd20, 12'd20, 1'b1}, 1'b0, '0},
    '{'{12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0}, 1'b0, '0},
    '{'{12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b1}, 1'b0, '0}
  };

  initial begin
    set_dropped = 1'b0;
    thr_num = bnms_pkg::OVERLAP_NUM_RST;
    thr_den = bnms_pkg::OVERLAP_DEN_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Typed rows are lone boxes that come straight back, marked last.
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        offer(rows[i].stim);
        kept_q = {kept_q, rows[i].want};
      end else begin
        send_box(rows[i].stim);
      end
    end
    drain();

    // Overflow: 66 boxes, the last two dropped; the final one still ends the set.
    for (int i = 0; i < 66; i++) send_box(rand_box(i == 65, 4095));
    drain();

    // Zero denominator: nothing is suppressed by overlap; then ratios 255/1 and 0/255.
    write_reg(bnms_pkg::REG_OVERLAP_DEN, 8'd0);
    send_set(6, 60);
    drain();
    write_reg(bnms_pkg::REG_OVERLAP_NUM, 8'hFF);
    write_reg(bnms_pkg::REG_OVERLAP_DEN, 8'h01);
    send_set(6, 60);
    drain();
    write_reg(bnms_pkg::REG_OVERLAP_NUM, 8'd0);
    write_reg(bnms_pkg::REG_OVERLAP_DEN, 8'hFF);
    send_set(6, 60);
    drain();

    // The receiver holds off while sets keep arriving.
    hold_cycles = 3000;
    send_set(8, 200);
    send_set(8, 200);
    send_set(8, 200);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_in_pct = (phase == 0) ? 19 : (phase == 1) ? 87 : 0;
      idle_out_pct = (phase == 0) ? 87 : (phase == 1) ? 19 : 0;
      write_reg(bnms_pkg::REG_OVERLAP_NUM, 8'($urandom_range(255)));
      write_reg(bnms_pkg::REG_OVERLAP_DEN, 8'($urandom_range(1, 255)));
      for (int s = 0; s < 9; s++)
        send_set($urandom_range(1, 14), ($urandom_range(3) == 0) ? 4095 : 300);
      drain();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
